// ----- rtl/core/sets_pkg.sv -----
// Shared types and codes for the shortest-elapsed thread scheduler.
`timescale 1ns / 1ps

package sets_pkg;

  // Event codes on the input beat.
  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_YIELD  = 3'd2;
  localparam logic [2:0] ACT_EXIT   = 3'd3;
  localparam logic [2:0] ACT_JOIN   = 3'd4;

  // Result codes on the output beat.
  localparam logic [2:0] RC_OK     = 3'd0;
  localparam logic [2:0] RC_FULL   = 3'd1;
  localparam logic [2:0] RC_ABSENT = 3'd2;
  localparam logic [2:0] RC_IDLE   = 3'd3;
  localparam logic [2:0] RC_NO_RUN = 3'd4;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_WAITING  = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_TICK,
    S_SCHED,
    S_REQ,
    S_START,
    S_SCAN,
    S_PICK,
    S_EXIT,
    S_EXITJ,
    S_JOIN,
    S_DONE
  } sets_state_t;

  // Commands from the sequencer to the ready chain.
  typedef struct packed {
    logic start;
    logic push;
    logic take;
  } sets_qcmd_t;

  // Per-cell control decoded by the ready chain.
  typedef struct packed {
    logic push;
    logic shift;
    logic occupied;
  } sets_cell_ctrl_t;

endpackage

// ----- rtl/core/sets_in_if.sv -----
// Event channel: valid/ready handshake with the event fields.
`timescale 1ns / 1ps

interface sets_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] target_id;
  logic       value_given;

  modport source(output valid, action, target_id, value_given, input ready);
  modport sink(input valid, action, target_id, value_given, output ready);
endinterface

// ----- rtl/core/sets_out_if.sv -----
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface sets_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_code;
  logic       running_valid;
  logic [3:0] running_id;
  logic [3:0] created_id;
  logic       caller_waits;

  modport source(output valid, result_code, running_valid, running_id, created_id,
                 caller_waits, input ready);
  modport sink(input valid, result_code, running_valid, running_id, created_id,
               caller_waits, output ready);
endinterface

// ----- rtl/core/sets_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sets_qcell.sv -----
// One cell of the ready chain: holds a queue entry and passes the scan token.
`timescale 1ns / 1ps

module sets_qcell
  import sets_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IW    = 4,
  parameter int EW    = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  sets_cell_ctrl_t ctrl,
  input  logic [IW-1:0]   push_id,
  input  logic [EW-1:0]   push_e,
  input  logic [IW-1:0]   next_id,
  input  logic [EW-1:0]   next_e,
  input  logic            tok_in,
  input  logic [EW-1:0]   best_e_in,
  input  logic [IW-1:0]   best_pos_in,
  input  logic [IW-1:0]   best_id_in,
  output logic [IW-1:0]   id,
  output logic [EW-1:0]   e,
  output logic            tok_out,
  output logic [EW-1:0]   best_e_out,
  output logic [IW-1:0]   best_pos_out,
  output logic [IW-1:0]   best_id_out
);

  localparam bit FIRST = (INDEX == 0);

  logic take_own;

  // Strictly smaller wins, so the earliest entry keeps a tie.
  assign take_own = ctrl.occupied && (FIRST || (e < best_e_in));

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      id <= push_id;
      e  <= push_e;
    end else if (ctrl.shift) begin
      id <= next_id;
      e  <= next_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      if (take_own) begin
        best_e_out   <= e;
        best_pos_out <= IW'(INDEX);
        best_id_out  <= id;
      end else begin
        best_e_out   <= best_e_in;
        best_pos_out <= best_pos_in;
        best_id_out  <= best_id_in;
      end
    end
  end

endmodule

// ----- rtl/core/sets_queue.sv -----
// Ready order as a row of cells: tail append, minimum scan, remove-and-close-gap.
`timescale 1ns / 1ps

module sets_queue
  import sets_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int EW    = 16,
  parameter int CNTW  = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  sets_qcmd_t      cmd,
  input  logic [IW-1:0]   push_id,
  input  logic [EW-1:0]   push_e,
  output logic [CNTW-1:0] count,
  output logic            done,
  output logic [IW-1:0]   best_id
);

  logic [IW-1:0] c_id       [DEPTH];
  logic [EW-1:0] c_e        [DEPTH];
  logic          c_tok      [DEPTH];
  logic [EW-1:0] c_best_e   [DEPTH];
  logic [IW-1:0] c_best_pos [DEPTH];
  logic [IW-1:0] c_best_id  [DEPTH];
  logic [IW-1:0] best_pos;
  logic          push_ok;

  assign push_ok  = cmd.push && (count < CNTW'(DEPTH));
  assign best_pos = c_best_pos[DEPTH-1];
  assign done     = c_tok[DEPTH-1];
  assign best_id  = c_best_id[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push_ok) begin
      count <= count + 1'b1;
    end else if (cmd.take) begin
      count <= count - 1'b1;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    sets_cell_ctrl_t ctrl;
    logic            tok_in;
    logic [EW-1:0]   be_in;
    logic [IW-1:0]   bp_in;
    logic [IW-1:0]   bi_in;
    logic [IW-1:0]   nx_id;
    logic [EW-1:0]   nx_e;

    assign ctrl.push     = push_ok && (CNTW'(k) == count);
    assign ctrl.shift    = cmd.take && (IW'(k) >= best_pos);
    assign ctrl.occupied = CNTW'(k) < count;

    if (k == 0) begin : g_head
      assign tok_in = cmd.start;
      assign be_in  = '0;
      assign bp_in  = '0;
      assign bi_in  = '0;
    end else begin : g_body
      assign tok_in = c_tok[k-1];
      assign be_in  = c_best_e[k-1];
      assign bp_in  = c_best_pos[k-1];
      assign bi_in  = c_best_id[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign nx_id = '0;
      assign nx_e  = '0;
    end else begin : g_mid
      assign nx_id = c_id[k+1];
      assign nx_e  = c_e[k+1];
    end

    sets_qcell #(
      .INDEX(k),
      .IW   (IW),
      .EW   (EW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .push_id     (push_id),
      .push_e      (push_e),
      .next_id     (nx_id),
      .next_e      (nx_e),
      .tok_in      (tok_in),
      .best_e_in   (be_in),
      .best_pos_in (bp_in),
      .best_id_in  (bi_in),
      .id          (c_id[k]),
      .e           (c_e[k]),
      .tok_out     (c_tok[k]),
      .best_e_out  (c_best_e[k]),
      .best_pos_out(c_best_pos[k]),
      .best_id_out (c_best_id[k])
    );
  end

endmodule

// ----- rtl/core/shortest_elapsed_thread_scheduler.sv -----
// A create walks the slots for the lowest free one, one slot a cycle; tick, yield, exit and join
// wait on the scan token walking the ready chain one cell a cycle. One event is in flight at a
// time and the next is taken the cycle after the beat loads; a waiting beat holds the next at its
// end.
// Reset (synchronous) frees every slot, empties the ready chain and leaves no thread running.
`timescale 1ns / 1ps

module shortest_elapsed_thread_scheduler
  import sets_pkg::*;
#(
  parameter int MAX_THREADS  = 16,
  parameter int ELAPSED_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  sets_in_if.sink    in,
  sets_out_if.source out
);

  localparam int IW   = $clog2(MAX_THREADS);
  localparam int CNTW = $clog2(MAX_THREADS + 1);
  localparam int EW   = ELAPSED_BITS;

  sets_state_t state, state_next;

  logic [IW-1:0]          cnt, cnt_next;
  logic [2:0]             act, act_next;
  logic [3:0]             tgt, tgt_next;
  logic                   given, given_next;
  logic                   cur_valid, cur_valid_next;
  logic [IW-1:0]          cur_id, cur_id_next;
  logic [IW-1:0]          wake_id, wake_id_next;
  logic [2:0]             code, code_next;
  logic [3:0]             created, created_next;
  logic                   waits, waits_next;
  logic [MAX_THREADS-1:0] used, used_next;

  logic       o_valid;
  logic [2:0] o_code;
  logic       o_rv;
  logic [3:0] o_rid;
  logic [3:0] o_created;
  logic       o_waits;
  logic       out_load;

  // Slot storage ports.
  logic [IW-1:0] raddr;
  logic          rd_used;
  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [2:0]    st_wdata;
  logic [2:0]    st_rd;
  logic          el_we;
  logic [IW-1:0] el_waddr;
  logic [EW-1:0] el_wdata;
  logic [EW-1:0] el_rd;
  logic          jn_we;
  logic [IW-1:0] jn_waddr;
  logic [IW:0]   jn_wdata;
  logic [IW:0]   jn_rd;
  status_t       st_eff;

  // Ready chain.
  sets_qcmd_t      q_cmd;
  logic [IW-1:0]   q_push_id;
  logic [EW-1:0]   q_push_e;
  logic [CNTW-1:0] q_count;
  logic            q_done;
  logic [IW-1:0]   q_best_id;

  sets_ram #(.WIDTH(3), .DEPTH(MAX_THREADS)) u_status (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(raddr), .rdata(st_rd)
  );

  sets_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_elapsed (
    .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata), .raddr(raddr), .rdata(el_rd)
  );

  sets_ram #(.WIDTH(IW + 1), .DEPTH(MAX_THREADS)) u_joiner (
    .clk(clk), .we(jn_we), .waddr(jn_waddr), .wdata(jn_wdata), .raddr(raddr), .rdata(jn_rd)
  );

  sets_queue #(
    .DEPTH(MAX_THREADS),
    .IW   (IW),
    .EW   (EW),
    .CNTW (CNTW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .cmd    (q_cmd),
    .push_id(q_push_id),
    .push_e (q_push_e),
    .count  (q_count),
    .done   (q_done),
    .best_id(q_best_id)
  );

  // A slot that is not in use reads as free.
  assign st_eff = rd_used ? status_t'(st_rd) : ST_FREE;

  always_ff @(posedge clk) begin
    rd_used <= used[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_valid <= 1'b0;
      cur_id    <= '0;
      used      <= '0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      cur_valid <= cur_valid_next;
      cur_id    <= cur_id_next;
      used      <= used_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    act     <= act_next;
    tgt     <= tgt_next;
    given   <= given_next;
    code    <= code_next;
    created <= created_next;
    waits   <= waits_next;
    wake_id <= wake_id_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    act_next       = act;
    tgt_next       = tgt;
    given_next     = given;
    cur_valid_next = cur_valid;
    cur_id_next    = cur_id;
    wake_id_next   = wake_id;
    code_next      = code;
    created_next   = created;
    waits_next     = waits;
    used_next      = used;
    in.ready       = 1'b0;
    out_load       = 1'b0;
    raddr          = cur_id;
    st_we          = 1'b0;
    st_waddr       = cur_id;
    st_wdata       = ST_FREE;
    el_we          = 1'b0;
    el_waddr       = cur_id;
    el_wdata       = '0;
    jn_we          = 1'b0;
    jn_waddr       = cur_id;
    jn_wdata       = '0;
    q_cmd          = '0;
    q_push_id      = cur_id;
    q_push_e       = el_rd;

    case (state)
      S_IDLE: begin
        in.ready = 1'b1;
        if (in.valid) begin
          act_next     = in.action;
          tgt_next     = in.target_id;
          given_next   = in.value_given;
          code_next    = RC_OK;
          created_next = '0;
          waits_next   = 1'b0;
          cnt_next     = '0;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (act)
          ACT_CREATE: state_next = S_FIND;
          ACT_TICK:   state_next = cur_valid ? S_TICK : S_SCHED;
          ACT_YIELD:  state_next = S_SCHED;
          ACT_EXIT: begin
            if (!cur_valid) begin
              code_next  = RC_NO_RUN;
              state_next = S_DONE;
            end else begin
              state_next = S_EXIT;
            end
          end
          ACT_JOIN: begin
            if (!cur_valid) begin
              code_next  = RC_NO_RUN;
              state_next = S_DONE;
            end else if (32'(tgt) >= MAX_THREADS) begin
              code_next  = RC_ABSENT;
              state_next = S_DONE;
            end else begin
              raddr      = IW'(tgt);
              state_next = S_JOIN;
            end
          end
          default: state_next = S_DONE;
        endcase
      end

      // Walk the slots for the lowest free one.
      S_FIND: begin
        if (!used[cnt]) begin
          st_we          = 1'b1;
          st_waddr       = cnt;
          st_wdata       = ST_READY;
          el_we          = 1'b1;
          el_waddr       = cnt;
          jn_we          = 1'b1;
          jn_waddr       = cnt;
          used_next[cnt] = 1'b1;
          q_cmd.push     = 1'b1;
          q_push_id      = cnt;
          q_push_e       = '0;
          created_next   = 4'(cnt);
          state_next     = S_DONE;
        end else if (cnt == IW'(MAX_THREADS - 1)) begin
          code_next  = RC_FULL;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // Saturating count for the running thread.
      S_TICK: begin
        el_we      = 1'b1;
        el_wdata   = (el_rd == '1) ? el_rd : el_rd + 1'b1;
        state_next = S_SCHED;
      end

      S_SCHED: begin
        state_next = cur_valid ? S_REQ : S_START;
      end

      // Requeue the running thread at the tail.
      S_REQ: begin
        if (st_eff == ST_RUNNING) begin
          st_we      = 1'b1;
          st_wdata   = ST_READY;
          q_cmd.push = 1'b1;
        end
        cur_valid_next = 1'b0;
        state_next     = S_START;
      end

      S_START: begin
        if (q_count == '0) begin
          code_next  = RC_IDLE;
          state_next = S_DONE;
        end else begin
          q_cmd.start = 1'b1;
          state_next  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (q_done) begin
          state_next = S_PICK;
        end
      end

      S_PICK: begin
        q_cmd.take     = 1'b1;
        cur_id_next    = q_best_id;
        cur_valid_next = 1'b1;
        st_we          = 1'b1;
        st_waddr       = q_best_id;
        st_wdata       = ST_RUNNING;
        state_next     = S_DONE;
      end

      S_EXIT: begin
        if (jn_rd[IW]) begin
          raddr        = jn_rd[IW-1:0];
          wake_id_next = jn_rd[IW-1:0];
          state_next   = S_EXITJ;
        end else begin
          if (!given) begin
            used_next[cur_id] = 1'b0;
          end else begin
            st_we    = 1'b1;
            st_wdata = ST_FINISHED;
          end
          cur_valid_next = 1'b0;
          state_next     = S_START;
        end
      end

      // Wake a waiting joiner, then drop the exiting slot.
      S_EXITJ: begin
        if (st_eff == ST_WAITING) begin
          st_we      = 1'b1;
          st_waddr   = wake_id;
          st_wdata   = ST_READY;
          q_cmd.push = 1'b1;
          q_push_id  = wake_id;
        end
        used_next[cur_id] = 1'b0;
        cur_valid_next    = 1'b0;
        state_next        = S_START;
      end

      S_JOIN: begin
        if (st_eff == ST_FREE) begin
          code_next  = RC_ABSENT;
          state_next = S_DONE;
        end else if (st_eff == ST_FINISHED) begin
          if (given) begin
            used_next[IW'(tgt)] = 1'b0;
          end
          state_next = S_DONE;
        end else begin
          jn_we          = 1'b1;
          jn_waddr       = IW'(tgt);
          jn_wdata       = {1'b1, cur_id};
          st_we          = 1'b1;
          st_wdata       = ST_WAITING;
          waits_next     = 1'b1;
          cur_valid_next = 1'b0;
          state_next     = S_START;
        end
      end

      S_DONE: begin
        if (!o_valid || out.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_code    <= code;
      o_rv      <= cur_valid;
      o_rid     <= cur_valid ? 4'(cur_id) : 4'd0;
      o_created <= created;
      o_waits   <= waits;
    end
  end

  assign out.valid         = o_valid;
  assign out.result_code   = o_code;
  assign out.running_valid = o_rv;
  assign out.running_id    = o_rid;
  assign out.created_id    = o_created;
  assign out.caller_waits  = o_waits;

  a_cur_in_use: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> used[cur_id])
    else $error("running thread sits in a free slot");

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNTW'(MAX_THREADS))
    else $error("ready chain holds more entries than slots");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    q_done |-> state == S_SCAN)
    else $error("scan token left the chain outside a scan");

  a_pick_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> q_count != '0)
    else $error("pick from an empty ready chain");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    out_load |=> state == S_IDLE && o_valid)
    else $error("result beat not loaded on completion");

endmodule
